@@ hdl/uup_pkg.sv @@
// Shared constants and types of the UUID text parser.
package uup_pkg;

	localparam int unsigned UUID_BYTES = 16;
	localparam int unsigned COUNT_W    = $clog2(UUID_BYTES) + 1;
	localparam int unsigned INDEX_W    = $clog2(UUID_BYTES);
	localparam int unsigned VALUE_W    = UUID_BYTES * 8;

	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_OPEN  = 8'h7B;
	localparam logic [7:0] CH_CLOSE = 8'h7D;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] HEX_TEN  = 8'd10;

	// Character classes of one input character.
	typedef struct packed {
		logic       is_dash;
		logic       is_hex;
		logic       is_open;
		logic       is_close;
		logic [3:0] nib;
	} char_class_t;

	// Result of one finished text.
	typedef struct packed {
		logic               ok;
		logic [VALUE_W-1:0] value;
	} parse_result_t;

endpackage

@@ hdl/uup_decode.sv @@
// Character classifier: dash, brace and hex digit decode.
module uup_decode
	import uup_pkg::*;
(
	input  logic [7:0]  char_code,
	output char_class_t cls
);

	logic [7:0] digit;

	always_comb begin
		digit        = 8'd0;
		cls.is_dash  = (char_code == CH_DASH);
		cls.is_open  = (char_code == CH_OPEN);
		cls.is_close = (char_code == CH_CLOSE);
		cls.is_hex   = 1'b1;
		if (char_code inside {[CH_0:CH_9]}) begin
			digit = char_code - CH_0;
		end else if (char_code inside {[CH_LA:CH_LF]}) begin
			digit = char_code - CH_LA + HEX_TEN;
		end else if (char_code inside {[CH_UA:CH_UF]}) begin
			digit = char_code - CH_UA + HEX_TEN;
		end else begin
			cls.is_hex = 1'b0;
		end
		cls.nib = digit[3:0];
	end

endmodule

@@ hdl/uup_accum.sv @@
// Parse state: brace tracking, nibble pairing, byte store and error latch.
module uup_accum
	import uup_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  char_class_t   cls,
	input  logic          is_final,
	output parse_result_t result
);

	logic [VALUE_W-1:0] store_q, store_n;
	logic [COUNT_W-1:0] count_q, count_n;
	logic [3:0]         half_nib_q, half_nib_n;
	logic               half_q, half_n;
	logic               failed_q, failed_n;
	logic               at_start_q;
	logic               opened_q, opened_n;
	logic               skip;
	logic [INDEX_W-1:0] pos;

	always_comb begin
		store_n    = store_q;
		count_n    = count_q;
		half_nib_n = half_nib_q;
		half_n     = half_q;
		failed_n   = failed_q;
		opened_n   = opened_q;
		skip       = 1'b0;
		pos        = ~count_q[INDEX_W-1:0];

		if (at_start_q && !is_final && cls.is_open) begin
			opened_n = 1'b1;
			skip     = 1'b1;
		end else if (is_final && opened_q) begin
			if (cls.is_close) begin
				skip = 1'b1;
			end else begin
				failed_n = 1'b1;
			end
		end

		if (!skip && !failed_n && !cls.is_dash) begin
			if (!cls.is_hex) begin
				failed_n = 1'b1;
			end else if (!half_q) begin
				half_nib_n = cls.nib;
				half_n     = 1'b1;
			end else if (count_q[COUNT_W-1]) begin
				failed_n = 1'b1;
			end else begin
				// Byte 0 lands in the top byte of the value.
				store_n[{pos, 3'b000} +: 8] = {half_nib_q, cls.nib};
				count_n = count_q + 1'b1;
				half_n  = 1'b0;
			end
		end

		result.ok    = !failed_n && (count_n == COUNT_W'(UUID_BYTES)) && !half_n;
		result.value = result.ok ? store_n : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			half_nib_q <= '0;
			half_q     <= 1'b0;
			failed_q   <= 1'b0;
			at_start_q <= 1'b1;
			opened_q   <= 1'b0;
		end else if (step) begin
			if (is_final) begin
				count_q    <= '0;
				half_nib_q <= '0;
				half_q     <= 1'b0;
				failed_q   <= 1'b0;
				at_start_q <= 1'b1;
				opened_q   <= 1'b0;
			end else begin
				count_q    <= count_n;
				half_nib_q <= half_nib_n;
				half_q     <= half_n;
				failed_q   <= failed_n;
				at_start_q <= 1'b0;
				opened_q   <= opened_n;
			end
		end
	end

	// Every byte is written before a valid result reads it, so no reset.
	always_ff @(posedge clk) begin
		if (step) begin
			store_q <= store_n;
		end
	end

endmodule

@@ hdl/uuid_text_parser.sv @@
// Top level of the UUID text parser: input register, parse logic, result register.
//
// The block reads a UUID text one character per transaction on the input
// channel (char_code, is_final; in_valid/in_ready) and gives one result
// transaction (ok, value_upper, value_lower; out_valid/out_ready) for each
// character marked is_final. Characters without the final mark give nothing.
// Dashes are ignored, hex digits of either case pair into bytes, and an
// outer pair of braces is allowed. On an invalid text ok is low and both
// value words are zero.
// A final character is accepted into the input register and parsed from there,
// and its result enters the result register when that register is free; the
// result is taken from the result register.
// Throughput: one character per cycle while in_ready is high; the parse step
// between the input register and the parse state is combinational.
// When the receiver stalls, the result is held in the result register and
// a non-final character still moves on; a final character waits in the
// input register, and only then does in_ready drop.
// Reset clears the input and result valid flags and the parse state, so the
// next character starts a new text.
module uuid_text_parser
	import uup_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  char_code,
	input  logic        is_final,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        ok,
	output logic [63:0] value_upper,
	output logic [63:0] value_lower
);

	logic          valid_s1;
	logic [7:0]    char_s1;
	logic          final_s1;
	logic          out_valid_q;
	logic          ok_q;
	logic [VALUE_W-1:0] value_q;
	logic          out_free;
	logic          advance;
	char_class_t   cls;
	parse_result_t result;

	// The result register can take a new result when empty or being emptied.
	assign out_free = !out_valid_q || out_ready;
	// Only a final character needs room in the result register.
	assign advance  = valid_s1 && (!final_s1 || out_free);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1  <= char_code;
			final_s1 <= is_final;
		end
	end

	uup_decode u_decode (
		.char_code (char_s1),
		.cls       (cls)
	);

	uup_accum u_accum (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.cls      (cls),
		.is_final (final_s1),
		.result   (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && final_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && advance && final_s1) begin
			ok_q    <= result.ok;
			value_q <= result.value;
		end
	end

	assign out_valid   = out_valid_q;
	assign ok          = ok_q;
	assign value_upper = value_q[VALUE_W-1 -: 64];
	assign value_lower = value_q[63:0];

endmodule

@@ hdl/uup_checker.sv @@
// Port-level checks of the UUID text parser, bound to the top level.
module uup_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [7:0]  char_code,
	input logic        is_final,
	input logic        out_valid,
	input logic        out_ready,
	input logic        ok,
	input logic [63:0] value_upper,
	input logic [63:0] value_lower
);

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(ok)
			&& $stable(value_upper) && $stable(value_lower))
		else $error("result changed while stalled");

	// An invalid text reports an all-zero value.
	a_zero_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !ok |-> value_upper == 64'd0 && value_lower == 64'd0)
		else $error("nonzero value on invalid text");

	// A fresh result follows an accepted final character.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready && is_final, 2))
		else $error("result without a final character");

	// The input side stalls only behind a held result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without an output stall");

endmodule

bind uuid_text_parser uup_checker u_checker (.*);
